// ===== hw/rtl/wlrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlrs_pkg
// Shared sizes, codes and types for the wear-leveled record slot block.
// ----------------------------------------------------------------------------
package wlrs_pkg;

	// area geometry
	localparam int SLOT_COUNT     = 80;
	localparam int WORDS_PER_SLOT = 62;

	// derived widths
	localparam int SLOT_W  = $clog2(SLOT_COUNT);
	localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
	localparam int ADDR_W  = $clog2(SLOT_COUNT * WORDS_PER_SLOT);
	localparam int WORD_W  = 16;
	localparam int IDX_W   = 6;
	localparam int SLOTO_W = 7;

	// erased flash word
	localparam logic [WORD_W-1:0] ERASED_WORD = 16'hFFFF;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_RANGE   = 2'd1,
		STAT_NO_REC  = 2'd2,
		STAT_NO_OPEN = 2'd3
	} status_t;

	// control sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT
	} fsm_t;

	// request to the word memory
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} ram_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wlrs_word_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wlrs_word_ram
// Single-port word store for all record slots, registered read data.
// ----------------------------------------------------------------------------
module wlrs_word_ram (
	input  wire logic                       clk,
	input  wire wlrs_pkg::ram_req_t         req,
	output logic [wlrs_pkg::WORD_W-1:0]     rdata
);

	localparam int DEPTH = wlrs_pkg::SLOT_COUNT * wlrs_pkg::WORDS_PER_SLOT;

	logic [wlrs_pkg::WORD_W-1:0] mem [DEPTH];
	logic [wlrs_pkg::WORD_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/wear_leveled_record_slots.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wear_leveled_record_slots
// Rotating record slots with whole-area erase when the slots run out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request word: op, start_req,
// word_index, word_value. Output channel (out_valid/out_ready) returns one
// result word per request: read_value, status, slot, erased_all.
// Slots are claimed in ascending order, so the area is tracked by a count of
// used slots; the valid record is always the last claimed slot. Payload words
// live in one single-port memory. Per-word written flags for the open slot
// make unwritten words of a fresh slot read as 0xFFFF, so an erase takes no
// sweep of the memory.
// Timing: a request is taken in ST_IDLE and executed in ST_EXEC, which waits
// while the output register is still full; reads also pass through ST_RDWAIT
// for the registered memory read. One request is in flight at a time.
// Reset: all slots free, no open record; the block is ready right after
// reset. A finished result sits in the output register; while the receiver
// stalls, the next request is still taken and waits before execution.
// ----------------------------------------------------------------------------
module wear_leveled_record_slots (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         op,
	input  wire logic                         start_req,
	input  wire logic [wlrs_pkg::IDX_W-1:0]   word_index,
	input  wire logic [wlrs_pkg::WORD_W-1:0]  word_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [wlrs_pkg::WORD_W-1:0]       read_value,
	output logic [1:0]                        status,
	output logic [wlrs_pkg::SLOTO_W-1:0]      slot,
	output logic                              erased_all
);

	localparam int IDX_W  = wlrs_pkg::IDX_W;
	localparam int SLOT_W = wlrs_pkg::SLOT_W;
	localparam int CNT_W  = wlrs_pkg::CNT_W;
	localparam int ADDR_W = wlrs_pkg::ADDR_W;
	localparam int WORD_W = wlrs_pkg::WORD_W;
	localparam int WPS    = wlrs_pkg::WORDS_PER_SLOT;
	localparam int CMP_W  = IDX_W + $clog2(WPS + 1);

	// sequencer
	wlrs_pkg::fsm_t state_q, state_d;

	// captured request
	logic              op_q, start_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] val_q;

	// slot tracking
	logic [CNT_W-1:0]  used_q, used_d;
	logic [WPS-1:0]    wval_q, wval_d;

	// output register
	logic                        out_valid_q;
	logic [WORD_W-1:0]           rv_q, rv_d;
	wlrs_pkg::status_t           st_q, st_d;
	logic [wlrs_pkg::SLOTO_W-1:0] slot_q, slot_d;
	logic                        er_q, er_d;
	logic                        load_out;

	// datapath
	logic              out_free;
	logic              idx_bad;
	logic              wrap;
	logic [CNT_W-1:0]  eff_used;
	logic [SLOT_W-1:0] tgt_slot;
	logic [ADDR_W-1:0] tgt_addr;
	logic [WORD_W-1:0] rdata;
	wlrs_pkg::ram_req_t ram_req;

	assign out_free = !out_valid_q || out_ready;
	assign idx_bad  = {{(CMP_W-IDX_W){1'b0}}, idx_q} >= CMP_W'(WPS);
	assign wrap     = used_q == CNT_W'(wlrs_pkg::SLOT_COUNT);

	// slot count after a possible allocation; the valid record is the last one
	always_comb begin
		eff_used = used_q;
		if (op_q && start_q) begin
			eff_used = wrap ? CNT_W'(1) : used_q + CNT_W'(1);
		end
	end

	assign tgt_slot = SLOT_W'(eff_used - CNT_W'(1));
	assign tgt_addr = ADDR_W'(tgt_slot * WPS) + ADDR_W'(idx_q);

	// next state, memory request and result
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		used_d   = used_q;
		wval_d   = wval_q;
		load_out = 1'b0;
		rv_d     = '0;
		st_d     = wlrs_pkg::STAT_OK;
		slot_d   = '0;
		er_d     = 1'b0;
		ram_req  = '{rd: 1'b0, wr: 1'b0, addr: tgt_addr, wdata: val_q};
		unique case (state_q)
			wlrs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = wlrs_pkg::ST_EXEC;
				end
			end
			wlrs_pkg::ST_EXEC: begin
				priority if (idx_bad) begin
					if (out_free) begin
						load_out = 1'b1;
						st_d     = wlrs_pkg::STAT_RANGE;
						state_d  = wlrs_pkg::ST_IDLE;
					end
				end else if (!op_q) begin
					if (used_q == '0) begin
						if (out_free) begin
							load_out = 1'b1;
							st_d     = wlrs_pkg::STAT_NO_REC;
							state_d  = wlrs_pkg::ST_IDLE;
						end
					end else begin
						ram_req.rd = 1'b1;
						state_d    = wlrs_pkg::ST_RDWAIT;
					end
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = wlrs_pkg::ST_IDLE;
					if (eff_used == '0) begin
						st_d = wlrs_pkg::STAT_NO_OPEN;
					end else begin
						// commit the word, and the allocation if any
						ram_req.wr = 1'b1;
						used_d     = eff_used;
						if (start_q) begin
							wval_d = '0;
						end
						wval_d[idx_q] = 1'b1;
						slot_d = wlrs_pkg::SLOTO_W'(tgt_slot);
						er_d   = start_q && wrap;
					end
				end
			end
			wlrs_pkg::ST_RDWAIT: begin
				if (out_free) begin
					load_out = 1'b1;
					rv_d     = wval_q[idx_q] ? rdata : wlrs_pkg::ERASED_WORD;
					slot_d   = wlrs_pkg::SLOTO_W'(tgt_slot);
					state_d  = wlrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wlrs_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer and slot tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wlrs_pkg::ST_IDLE;
			used_q      <= '0;
			wval_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			wval_q  <= wval_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the request word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			start_q <= start_req;
			idx_q   <= word_index;
			val_q   <= word_value;
		end
	end

	// hold the result word
	always_ff @(posedge clk) begin
		if (load_out) begin
			rv_q   <= rv_d;
			st_q   <= st_d;
			slot_q <= slot_d;
			er_q   <= er_d;
		end
	end

	wlrs_word_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	assign out_valid  = out_valid_q;
	assign read_value = rv_q;
	assign status     = st_q;
	assign slot       = slot_q;
	assign erased_all = er_q;

endmodule
`default_nettype wire
